// ===== src/ring_sector_vertex_generator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Ring sector vertex generator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RING_SECTOR_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define RING_SECTOR_VERTEX_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define RSVG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsvg: same-cycle check failed");

// next-cycle implication
`define RSVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsvg: next-cycle check failed");

`endif

// ===== src/rsvg_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring sector vertex generator package
// Shared types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rsvg_pkg;

   localparam int NUM_W        = 25;   // dividend width of the divider pipes
   localparam int DIV_CNT      = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 3;

   localparam int TWO_PI_Q16  = 411775;
   localparam int PI_Q16      = 205887;
   localparam int HALF_PI_Q16 = 102944;
   localparam int CORDIC_GAIN = 39797;
   localparam int TRIG_MAX    = 65536;
   localparam int TWO_PI_Q12  = 25736;

   // divider lanes
   localparam int DIV_A0    = 0;
   localparam int DIV_A1    = 1;
   localparam int DIV_ROUT0 = 2;
   localparam int DIV_RIN0  = 3;
   localparam int DIV_ROUT1 = 4;
   localparam int DIV_RIN1  = 5;
   localparam int DIV_U0    = 6;
   localparam int DIV_U1    = 7;

   typedef enum logic [2:0] {
      CSR_SLICE_COUNT = 3'd0,
      CSR_START_ANGLE = 3'd1,
      CSR_END_ANGLE   = 3'd2,
      CSR_START_INNER = 3'd3,
      CSR_START_OUTER = 3'd4,
      CSR_END_INNER   = 3'd5,
      CSR_END_OUTER   = 3'd6
   } csr_index_type;

   typedef logic [NUM_W-1:0] numer_type;

   typedef struct packed {
      logic [8:0]         slice_count;
      logic signed [15:0] start_angle;
      logic signed [15:0] end_angle;
      logic [15:0]        start_inner;
      logic [15:0]        start_outer;
      logic [15:0]        end_inner;
      logic [15:0]        end_outer;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] slice;
      logic       neg0;
      logic       neg1;
      logic       full;
   } div_side_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  slice;
      logic [15:0] rout0;
      logic [15:0] rin0;
      logic [15:0] rout1;
      logic [15:0] rin1;
      logic [16:0] u0;
      logic [16:0] u1;
   } geo_side_type;

   typedef struct packed {
      geo_side_type       geo;
      logic signed [17:0] sin0;
      logic signed [17:0] cos0;
      logic signed [17:0] sin1;
      logic signed [17:0] cos1;
   } corner_in_type;

   function automatic logic signed [19:0] atan_q16(input logic [3:0] k);
      logic signed [19:0] a;
      case (k)
         4'd0:    a = 20'sd51472;
         4'd1:    a = 20'sd30386;
         4'd2:    a = 20'sd16055;
         4'd3:    a = 20'sd8150;
         4'd4:    a = 20'sd4091;
         4'd5:    a = 20'sd2047;
         4'd6:    a = 20'sd1024;
         4'd7:    a = 20'sd512;
         4'd8:    a = 20'sd256;
         4'd9:    a = 20'sd128;
         4'd10:   a = 20'sd64;
         4'd11:   a = 20'sd32;
         4'd12:   a = 20'sd16;
         4'd13:   a = 20'sd8;
         4'd14:   a = 20'sd4;
         default: a = 20'sd2;
      endcase
      return a;
   endfunction

endpackage

// ===== src/rsvg_req_if.sv =====
// ----------------------------------------------------------------------------
// Slice request channel
// Valid/ready channel carrying one slice index per word.
// ----------------------------------------------------------------------------
interface rsvg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] slice_index;

   modport source (output valid, output slice_index, input ready);
   modport sink (input valid, input slice_index, output ready);
endinterface

// ===== src/rsvg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Vertex response channel
// Valid/ready channel carrying one vertex per word.
// ----------------------------------------------------------------------------
interface rsvg_rsp_if;
   logic               valid;
   logic               ready;
   logic [9:0]         vertex_number;
   logic signed [16:0] pos_x;
   logic signed [16:0] pos_y;
   logic [16:0]        tex_u;
   logic               tex_v;
   logic               last_vertex;

   modport source (output valid, output vertex_number, output pos_x, output pos_y,
                   output tex_u, output tex_v, output last_vertex, input ready);
   modport sink (input valid, input vertex_number, input pos_x, input pos_y,
                 input tex_u, input tex_v, input last_vertex, output ready);
endinterface

// ===== src/rsvg_numer.sv =====
// ----------------------------------------------------------------------------
// Numerator front end
// Three stages: capture, products, rounded dividends for the divider lanes.
// ----------------------------------------------------------------------------
module rsvg_numer import rsvg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [7:0]   in_slice,
   input  cfg_type      cfg,
   input  logic [8:0]   slice_n,
   output numer_type    num_out [DIV_CNT],
   output div_side_type side_out
);

   logic               v1_ff, v2_ff;
   logic [7:0]         i1_ff, i2_ff;
   logic signed [16:0] sweep;
   logic [8:0]         k0, k1, w0, w1, k0b, k1b;
   logic signed [26:0] pa0_in, pa1_in, pa0_ff, pa1_ff;
   logic signed [26:0] mag0, mag1;
   logic [24:0]        prod_in [8];
   logic [24:0]        prod_ff [8];
   logic               full_in, full2_ff;
   numer_type          half;
   numer_type          num_in [DIV_CNT];
   numer_type          num_ff [DIV_CNT];
   div_side_type       side_in, side_ff;

   assign sweep = {cfg.end_angle[15], cfg.end_angle} - {cfg.start_angle[15], cfg.start_angle};

   // products stage
   always_comb begin
      k0 = {1'b0, i1_ff};
      k1 = k0 + 9'd1;
      w0 = slice_n - k0;
      w1 = w0 - 9'd1;
      pa0_in = $signed({1'b0, k0}) * sweep;
      pa1_in = $signed({1'b0, k1}) * sweep;
      prod_in[0] = 25'(cfg.start_outer) * 25'(w0);
      prod_in[1] = 25'(cfg.end_outer) * 25'(k0);
      prod_in[2] = 25'(cfg.start_inner) * 25'(w0);
      prod_in[3] = 25'(cfg.end_inner) * 25'(k0);
      prod_in[4] = 25'(cfg.start_outer) * 25'(w1);
      prod_in[5] = 25'(cfg.end_outer) * 25'(k1);
      prod_in[6] = 25'(cfg.start_inner) * 25'(w1);
      prod_in[7] = 25'(cfg.end_inner) * 25'(k1);
      // full circle closes back onto the start angle
      full_in = (k0 == slice_n - 9'd1) && (sweep >= 17'(TWO_PI_Q12 - 1))
                && (sweep <= 17'(TWO_PI_Q12 + 1));
   end

   // dividend stage
   always_comb begin
      half = NUM_W'(slice_n[8:1]);
      k0b  = {1'b0, i2_ff};
      k1b  = k0b + 9'd1;
      mag0 = pa0_ff[26] ? -pa0_ff : pa0_ff;
      mag1 = pa1_ff[26] ? -pa1_ff : pa1_ff;
      num_in[DIV_A0]    = mag0[NUM_W-1:0] + half;
      num_in[DIV_A1]    = mag1[NUM_W-1:0] + half;
      num_in[DIV_ROUT0] = prod_ff[0] + prod_ff[1] + half;
      num_in[DIV_RIN0]  = prod_ff[2] + prod_ff[3] + half;
      num_in[DIV_ROUT1] = prod_ff[4] + prod_ff[5] + half;
      num_in[DIV_RIN1]  = prod_ff[6] + prod_ff[7] + half;
      num_in[DIV_U0]    = {k0b, 16'd0} + half;
      num_in[DIV_U1]    = {k1b, 16'd0} + half;
      side_in.valid = v2_ff;
      side_in.slice = i2_ff;
      side_in.neg0  = pa0_ff[26];
      side_in.neg1  = pa1_ff[26];
      side_in.full  = full2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         side_ff <= '0;
      end else if (en) begin
         // drop indices at or beyond the slice count
         v1_ff   <= in_valid && ({1'b0, in_slice} < slice_n);
         v2_ff   <= v1_ff;
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i1_ff    <= in_slice;
         i2_ff    <= i1_ff;
         pa0_ff   <= pa0_in;
         pa1_ff   <= pa1_in;
         full2_ff <= full_in;
         for (int p = 0; p < 8; p++) begin
            prod_ff[p] <= prod_in[p];
         end
         for (int d = 0; d < DIV_CNT; d++) begin
            num_ff[d] <= num_in[d];
         end
      end
   end

   assign num_out  = num_ff;
   assign side_out = side_ff;

endmodule

// ===== src/rsvg_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rsvg_div import rsvg_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  numer_type        dividend,
   input  logic [8:0]       divisor,
   output numer_type        quotient
);

   logic [8:0] rem_in [NUM_W];
   logic [8:0] rem_ff [NUM_W];
   numer_type  num_in [NUM_W];
   numer_type  num_ff [NUM_W];
   numer_type  quo_in [NUM_W];
   numer_type  quo_ff [NUM_W];

   always_comb begin
      logic [8:0] rem_src;
      numer_type  num_src, quo_src;
      logic [9:0] trial;
      for (int j = 0; j < NUM_W; j++) begin
         if (j == 0) begin
            rem_src = '0;
            num_src = dividend;
            quo_src = '0;
         end else begin
            rem_src = rem_ff[j-1];
            num_src = num_ff[j-1];
            quo_src = quo_ff[j-1];
         end
         trial = {rem_src, num_src[NUM_W-1]};
         if (trial >= {1'b0, divisor}) begin
            rem_in[j] = 9'(trial - {1'b0, divisor});
            quo_in[j] = {quo_src[NUM_W-2:0], 1'b1};
         end else begin
            rem_in[j] = trial[8:0];
            quo_in[j] = {quo_src[NUM_W-2:0], 1'b0};
         end
         num_in[j] = {num_src[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NUM_W; j++) begin
            rem_ff[j] <= rem_in[j];
            num_ff[j] <= num_in[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quotient = quo_ff[NUM_W-1];

endmodule

// ===== src/rsvg_cordic.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine pipeline
// Range reduction, quadrant fold, sixteen CORDIC rotations and a clamp.
// ----------------------------------------------------------------------------
module rsvg_cordic import rsvg_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [17:0] angle,
   output logic signed [17:0] sin_out,
   output logic signed [17:0] cos_out
);

   logic signed [22:0] z_full;
   logic signed [18:0] zr_in, zr_ff;
   logic signed [19:0] zf_in, zf_ff;
   logic               negf_in, negf_ff;
   logic signed [19:0] x_in [CORDIC_STEPS];
   logic signed [19:0] y_in [CORDIC_STEPS];
   logic signed [19:0] z_in [CORDIC_STEPS];
   logic signed [19:0] x_ff [CORDIC_STEPS];
   logic signed [19:0] y_ff [CORDIC_STEPS];
   logic signed [19:0] z_ff [CORDIC_STEPS];
   logic               neg_ff [CORDIC_STEPS];
   logic signed [19:0] xn, yn;
   logic signed [17:0] sin_in, cos_in, sin_ff, cos_ff;

   assign z_full = {angle[17], angle, 4'd0};

   // reduce into [-pi, pi]: count whole turns in parallel
   always_comb begin
      int m_pos, m_neg, zi;
      m_pos = 0;
      m_neg = 0;
      zi = int'(z_full);
      for (int j = 0; j < 5; j++) begin
         if (zi > PI_Q16 + j * TWO_PI_Q16) begin
            m_pos = m_pos + 1;
         end
         if (zi < -PI_Q16 - j * TWO_PI_Q16) begin
            m_neg = m_neg + 1;
         end
      end
      zr_in = 19'(zi + (m_neg - m_pos) * TWO_PI_Q16);
   end

   // fold into [-pi/2, pi/2], negate both results on a fold
   always_comb begin
      int zz;
      zz = int'(zr_ff);
      negf_in = 1'b0;
      if (zz > HALF_PI_Q16) begin
         zz = zz - PI_Q16;
         negf_in = 1'b1;
      end else if (zz < -HALF_PI_Q16) begin
         zz = zz + PI_Q16;
         negf_in = 1'b1;
      end
      zf_in = 20'(zz);
   end

   always_comb begin
      logic signed [19:0] xs, ys, zs, dx, dy;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (k == 0) begin
            xs = 20'(CORDIC_GAIN);
            ys = '0;
            zs = zf_ff;
         end else begin
            xs = x_ff[k-1];
            ys = y_ff[k-1];
            zs = z_ff[k-1];
         end
         dx = ys >>> k;
         dy = xs >>> k;
         if (zs >= 0) begin
            x_in[k] = xs - dx;
            y_in[k] = ys + dy;
            z_in[k] = zs - atan_q16(4'(k));
         end else begin
            x_in[k] = xs + dx;
            y_in[k] = ys - dy;
            z_in[k] = zs + atan_q16(4'(k));
         end
      end
   end

   // undo the fold and clamp to one
   always_comb begin
      xn = neg_ff[CORDIC_STEPS-1] ? -x_ff[CORDIC_STEPS-1] : x_ff[CORDIC_STEPS-1];
      yn = neg_ff[CORDIC_STEPS-1] ? -y_ff[CORDIC_STEPS-1] : y_ff[CORDIC_STEPS-1];
      if (xn > 20'(TRIG_MAX)) begin
         cos_in = 18'(TRIG_MAX);
      end else if (xn < -20'(TRIG_MAX)) begin
         cos_in = -18'(TRIG_MAX);
      end else begin
         cos_in = xn[17:0];
      end
      if (yn > 20'(TRIG_MAX)) begin
         sin_in = 18'(TRIG_MAX);
      end else if (yn < -20'(TRIG_MAX)) begin
         sin_in = -18'(TRIG_MAX);
      end else begin
         sin_in = yn[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zr_ff   <= zr_in;
         zf_ff   <= zf_in;
         negf_ff <= negf_in;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            z_ff[k]   <= z_in[k];
            neg_ff[k] <= (k == 0) ? negf_ff : neg_ff[(k == 0) ? 0 : k-1];
         end
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ===== src/rsvg_corner.sv =====
// ----------------------------------------------------------------------------
// Corner sequencer
// Holds one slice, walks its four corners, scales and saturates positions.
// ----------------------------------------------------------------------------
module rsvg_corner import rsvg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  corner_in_type  slice_in,
   output logic           take,
   rsvg_rsp_if.source     rsp_chan
);

   corner_in_type      hold_ff;
   logic               hold_v_ff;
   logic [1:0]         corner_ff;
   logic               en_b;
   logic signed [17:0] s_sel, c_sel;
   logic signed [18:0] s_neg;
   logic [15:0]        r_sel;
   logic signed [35:0] px_in, py_in, px_ff, py_ff;
   logic               m_v_ff;
   logic [9:0]         m_vn_ff;
   logic [16:0]        m_u_ff;
   logic               m_tv_ff, m_last_ff;
   logic               o_v_ff;
   logic [9:0]         o_vn_ff;
   logic signed [16:0] o_x_ff, o_y_ff;
   logic [16:0]        o_u_ff;
   logic               o_tv_ff, o_last_ff;

   function automatic logic signed [16:0] scale_round(input logic signed [35:0] p);
      logic signed [36:0] t;
      logic signed [20:0] q;
      t = {p[35], p} + 37'sd32768;
      q = t[36:16];
      if (q > 21'sd65535) begin
         return 17'sd65535;
      end else if (q < -21'sd65536) begin
         return -17'sd65536;
      end
      return q[16:0];
   endfunction

   assign en_b = !o_v_ff || rsp_chan.ready;
   assign take = en_b && (!hold_v_ff || corner_ff == 2'd3);

   always_comb begin
      s_sel = corner_ff[0] ? hold_ff.sin1 : hold_ff.sin0;
      c_sel = corner_ff[0] ? hold_ff.cos1 : hold_ff.cos0;
      case (corner_ff)
         2'd0:    r_sel = hold_ff.geo.rout0;
         2'd1:    r_sel = hold_ff.geo.rout1;
         2'd2:    r_sel = hold_ff.geo.rin0;
         default: r_sel = hold_ff.geo.rin1;
      endcase
      s_neg = -{s_sel[17], s_sel};
      px_in = s_neg * $signed({1'b0, r_sel});
      py_in = c_sel * $signed({1'b0, r_sel});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         corner_ff <= 2'd0;
         m_v_ff    <= 1'b0;
         o_v_ff    <= 1'b0;
      end else begin
         if (take) begin
            hold_v_ff <= slice_in.geo.valid;
            corner_ff <= 2'd0;
         end else if (en_b && hold_v_ff) begin
            corner_ff <= corner_ff + 2'd1;
         end
         if (en_b) begin
            m_v_ff <= hold_v_ff;
            o_v_ff <= m_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff <= slice_in;
      end
      if (en_b) begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         m_vn_ff   <= {hold_ff.geo.slice, corner_ff};
         m_u_ff    <= corner_ff[0] ? hold_ff.geo.u1 : hold_ff.geo.u0;
         m_tv_ff   <= corner_ff[1];
         m_last_ff <= (corner_ff == 2'd3);
         o_vn_ff   <= m_vn_ff;
         o_x_ff    <= scale_round(px_ff);
         o_y_ff    <= scale_round(py_ff);
         o_u_ff    <= m_u_ff;
         o_tv_ff   <= m_tv_ff;
         o_last_ff <= m_last_ff;
      end
   end

   assign rsp_chan.valid         = o_v_ff;
   assign rsp_chan.vertex_number = o_vn_ff;
   assign rsp_chan.pos_x         = o_x_ff;
   assign rsp_chan.pos_y         = o_y_ff;
   assign rsp_chan.tex_u         = o_u_ff;
   assign rsp_chan.tex_v         = o_tv_ff;
   assign rsp_chan.last_vertex   = o_last_ff;

endmodule

// ===== src/ring_sector_vertex_generator_top.sv =====
// Ring sector vertex generator: each accepted slice index below the slice
// count yields four vertex words (outer current, outer next, inner current,
// inner next); other indices yield none. The response port gives one vertex
// per cycle while the sink is ready; a new slice enters the sequencer as the
// held one reaches its last corner, and requests pass back to back while
// the pipeline has room, through three numerator stages, a 25-stage divider
// pipe, angle assembly, 19 sine/cosine stages and three output stages. The
// user must write the csr port registers only while no work is in flight;
// the block does not enforce it.
// Ring sector vertex generator top level
// Register file, divider lanes, sine/cosine pipes and corner sequencer.
// ----------------------------------------------------------------------------
`include "ring_sector_vertex_generator_top_assert.svh"

module ring_sector_vertex_generator_top import rsvg_pkg::*; #(
   parameter int MAX_SLICES = 256
) (
   input  logic        clock,
   input  logic        reset,
   rsvg_req_if.sink    req_chan,
   rsvg_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam logic [12:0] MaxSlices = 13'(MAX_SLICES);

   cfg_type            cfg_ff;
   logic [8:0]         slice_n;
   logic               en_f, take;
   numer_type          num [DIV_CNT];
   numer_type          quo [DIV_CNT];
   div_side_type       nside;
   div_side_type       dline_ff [NUM_W];
   logic signed [18:0] sq0, sq1, a0_in, a1_in, start_x;
   logic signed [17:0] ang0_ff, ang1_ff;
   geo_side_type       geo_in, geo_ff;
   geo_side_type       gline_ff [CORDIC_LAT];
   logic signed [17:0] sin0, cos0, sin1, cos1;
   corner_in_type      corner_in;
   logic               rsp_v, rsp_mid;
   logic [9:0]         rsp_vn;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slice_count <= 9'd32;
         cfg_ff.start_angle <= 16'sd0;
         cfg_ff.end_angle   <= 16'sd25736;
         cfg_ff.start_inner <= 16'd128;
         cfg_ff.start_outer <= 16'd256;
         cfg_ff.end_inner   <= 16'd128;
         cfg_ff.end_outer   <= 16'd256;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLICE_COUNT: cfg_ff.slice_count <= csr_write_data[8:0];
            CSR_START_ANGLE: cfg_ff.start_angle <= csr_write_data;
            CSR_END_ANGLE:   cfg_ff.end_angle   <= csr_write_data;
            CSR_START_INNER: cfg_ff.start_inner <= csr_write_data;
            CSR_START_OUTER: cfg_ff.start_outer <= csr_write_data;
            CSR_END_INNER:   cfg_ff.end_inner   <= csr_write_data;
            CSR_END_OUTER:   cfg_ff.end_outer   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign slice_n = ({4'd0, cfg_ff.slice_count} > MaxSlices) ? MaxSlices[8:0]
                                                            : cfg_ff.slice_count;

   // the front advances as one; hold it while the sequencer is busy
   assign en_f = !gline_ff[CORDIC_LAT-1].valid || take;
   assign req_chan.ready = en_f;

   rsvg_numer u_numer (
      .clock    (clock),
      .reset    (reset),
      .en       (en_f),
      .in_valid (req_chan.valid),
      .in_slice (req_chan.slice_index),
      .cfg      (cfg_ff),
      .slice_n  (slice_n),
      .num_out  (num),
      .side_out (nside)
   );

   for (genvar d = 0; d < DIV_CNT; d++) begin : g_div
      rsvg_div u_div (
         .clock    (clock),
         .en       (en_f),
         .dividend (num[d]),
         .divisor  (slice_n),
         .quotient (quo[d])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_W; j++) begin
            dline_ff[j] <= '0;
         end
      end else if (en_f) begin
         dline_ff[0] <= nside;
         for (int j = 1; j < NUM_W; j++) begin
            dline_ff[j] <= dline_ff[j-1];
         end
      end
   end

   // angle assembly
   always_comb begin
      start_x = {{3{cfg_ff.start_angle[15]}}, cfg_ff.start_angle};
      sq0 = dline_ff[NUM_W-1].neg0 ? -$signed({2'b0, quo[DIV_A0][16:0]})
                                   : $signed({2'b0, quo[DIV_A0][16:0]});
      sq1 = dline_ff[NUM_W-1].neg1 ? -$signed({2'b0, quo[DIV_A1][16:0]})
                                   : $signed({2'b0, quo[DIV_A1][16:0]});
      a0_in = start_x + sq0;
      a1_in = dline_ff[NUM_W-1].full ? start_x : start_x + sq1;
      geo_in.valid = dline_ff[NUM_W-1].valid;
      geo_in.slice = dline_ff[NUM_W-1].slice;
      geo_in.rout0 = quo[DIV_ROUT0][15:0];
      geo_in.rin0  = quo[DIV_RIN0][15:0];
      geo_in.rout1 = quo[DIV_ROUT1][15:0];
      geo_in.rin1  = quo[DIV_RIN1][15:0];
      geo_in.u0    = quo[DIV_U0][16:0];
      geo_in.u1    = quo[DIV_U1][16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff <= '0;
         for (int j = 0; j < CORDIC_LAT; j++) begin
            gline_ff[j] <= '0;
         end
      end else if (en_f) begin
         geo_ff      <= geo_in;
         gline_ff[0] <= geo_ff;
         for (int j = 1; j < CORDIC_LAT; j++) begin
            gline_ff[j] <= gline_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         ang0_ff <= a0_in[17:0];
         ang1_ff <= a1_in[17:0];
      end
   end

   rsvg_cordic u_cordic0 (
      .clock   (clock),
      .en      (en_f),
      .angle   (ang0_ff),
      .sin_out (sin0),
      .cos_out (cos0)
   );

   rsvg_cordic u_cordic1 (
      .clock   (clock),
      .en      (en_f),
      .angle   (ang1_ff),
      .sin_out (sin1),
      .cos_out (cos1)
   );

   assign corner_in.geo  = gline_ff[CORDIC_LAT-1];
   assign corner_in.sin0 = sin0;
   assign corner_in.cos0 = cos0;
   assign corner_in.sin1 = sin1;
   assign corner_in.cos1 = cos1;

   rsvg_corner u_corner (
      .clock    (clock),
      .reset    (reset),
      .slice_in (corner_in),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

   assign rsp_v   = rsp_chan.valid;
   assign rsp_vn  = rsp_chan.vertex_number;
   assign rsp_mid = rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_vertex;

   // each accepted corner but the last is followed at once by the slice's next corner
   `RSVG_ASSERT_NEXT(a_corner_run, clock, reset, rsp_mid, rsp_v && rsp_vn == $past(rsp_vn + 10'd1))
   `RSVG_ASSERT_IMPL(a_slice_start, clock, reset, $rose(rsp_v), rsp_vn[1:0] == 2'd0)
   `RSVG_ASSERT_IMPL(a_stall_cause, clock, reset, !req_chan.ready, gline_ff[CORDIC_LAT-1].valid)

endmodule
